// ===== hw/rtl/lvfr_pkg.sv =====
// ----------------------------------------------------------------------------
// lvfr_pkg
// Shared constants and types for the least-voted frame replacement block:
// default sizes, vote counter width, register map and the cell control word.
// ----------------------------------------------------------------------------
package lvfr_pkg;

  // Default sizes, handed to the top level parameters
  localparam int unsigned FRAMES_DEF  = 16;
  localparam int unsigned ID_BITS_DEF = 7;

  // Vote counter
  localparam int unsigned          VOTE_W   = 16;
  localparam logic [VOTE_W-1:0]    VOTE_MAX = 16'hFFFF;
  localparam logic [VOTE_W-1:0]    VOTE_ONE = 16'd1;

  // Configuration register map (word index = paddr[2])
  localparam int unsigned          CFG_W             = 5;
  localparam logic                 REG_FRAMES_IN_USE = 1'b0;
  localparam logic [CFG_W-1:0]     FIU_RESET         = 5'd16;

  // Per-cell control: shift takes the neighbour's word, load takes the push word
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/lvfr_cell.sv =====
// ----------------------------------------------------------------------------
// lvfr_cell
// One frame slot of the chain: holds an id and its vote count, takes the word
// of its upper neighbour on a shift, or the broadcast push word on a load.
// ----------------------------------------------------------------------------
module lvfr_cell #(
  parameter int unsigned ID_BITS = lvfr_pkg::ID_BITS_DEF
) (
  input  logic                        clk_i,
  input  lvfr_pkg::cell_ctrl_t        ctrl_i,
  input  logic [ID_BITS-1:0]          nb_id_i,
  input  logic [lvfr_pkg::VOTE_W-1:0] nb_votes_i,
  input  logic [ID_BITS-1:0]          push_id_i,
  input  logic [lvfr_pkg::VOTE_W-1:0] push_votes_i,
  output logic [ID_BITS-1:0]          id_o,
  output logic [lvfr_pkg::VOTE_W-1:0] votes_o
);
  import lvfr_pkg::*;

  logic [ID_BITS-1:0] id_q;
  logic [VOTE_W-1:0]  votes_q;

  // Slot contents: payload only, no reset
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      id_q    <= push_id_i;
      votes_q <= push_votes_i;
    end else if (ctrl_i.shift) begin
      id_q    <= nb_id_i;
      votes_q <= nb_votes_i;
    end
  end

  assign id_o    = id_q;
  assign votes_o = votes_q;

endmodule

// ===== hw/rtl/least_voted_frame_replacement_top.sv =====
// ----------------------------------------------------------------------------
// least_voted_frame_replacement_top
// LFU frame replacement with least-recent tie-break, built as a chain of
// frame cells that rotates one word per cycle past a scan/compare unit.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+------------------------------------
//  vote in   | in_valid_i / in_ready_o    | candidate_id_i
//  result    | out_valid_o / out_ready_i  | was_held_o, evict_valid_o,
//            |                            | evicted_id_o, vote_total_o,
//            |                            | frames_used_o
//  config    | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// A vote rotates the chain past the scan unit one frame per cycle, once to find
// a hit and the least-voted frame; when no frame is free and the id is not held,
// it rotates once more to remove the victim.
// Reset clears the occupancy count but not the frame cells; they need no clearing pass.
// A stalled result waits in the output register; the next vote is taken and
// processed meanwhile and waits at its end until the register is free.
// ----------------------------------------------------------------------------
module least_voted_frame_replacement_top #(
  parameter int unsigned FRAMES  = lvfr_pkg::FRAMES_DEF,
  parameter int unsigned ID_BITS = lvfr_pkg::ID_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // vote input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ID_BITS-1:0]            candidate_id_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          was_held_o,
  output logic                          evict_valid_o,
  output logic [ID_BITS-1:0]            evicted_id_o,
  output logic [lvfr_pkg::VOTE_W-1:0]   vote_total_o,
  output logic [$clog2(FRAMES+1)-1:0]   frames_used_o,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import lvfr_pkg::*;

  localparam int unsigned CNT_W = $clog2(FRAMES + 1);
  localparam int unsigned IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_PURGE  = 3'd2;
  localparam logic [2:0] ST_APPEND = 3'd3;
  localparam logic [2:0] ST_FIN    = 3'd4;

  logic [2:0]         state_q;
  logic [ID_BITS-1:0] cand_q;
  logic [CNT_W-1:0]   cnt_q;       // occupied frames
  logic [CNT_W-1:0]   tot_q;       // words to rotate in this pass
  logic [CNT_W-1:0]   k_q;         // words popped so far in this pass
  logic               found_q;
  logic [VOTE_W-1:0]  hit_votes_q;
  logic [IDX_W-1:0]   best_q;
  logic [VOTE_W-1:0]  best_v_q;
  logic               have_best_q;
  logic               evict_q;
  logic [ID_BITS-1:0] gone_q;
  logic [CFG_W-1:0]   fiu_q;

  logic               out_valid_q;
  logic               was_held_q;
  logic               evict_out_q;
  logic [ID_BITS-1:0] evicted_id_q;
  logic [VOTE_W-1:0]  total_q;
  logic [CNT_W-1:0]   used_q;

  // Chain wiring
  logic [ID_BITS-1:0] cell_id  [FRAMES];
  logic [VOTE_W-1:0]  cell_v   [FRAMES];
  logic [ID_BITS-1:0] nb_id    [FRAMES];
  logic [VOTE_W-1:0]  nb_v     [FRAMES];
  cell_ctrl_t         cell_ctrl[FRAMES];

  logic [ID_BITS-1:0] head_id;
  logic [VOTE_W-1:0]  head_v;
  logic [CNT_W-1:0]   lim;
  logic               room;
  logic               pop;
  logic               match;
  logic               drop;
  logic               load_any;
  logic [CNT_W-1:0]   cnt_m1;
  logic [IDX_W-1:0]   tail;
  logic [ID_BITS-1:0] push_id;
  logic [VOTE_W-1:0]  push_v;
  logic [VOTE_W-1:0]  new_v;
  logic               cfg_wr;
  logic               out_load;

  // Effective slot limit: 0 acts as 1, above FRAMES acts as FRAMES
  always_comb begin
    if (fiu_q == '0) begin
      lim = CNT_W'(1);
    end else if (32'(fiu_q) > FRAMES) begin
      lim = CNT_W'(FRAMES);
    end else begin
      lim = CNT_W'(fiu_q);
    end
  end
  assign room = (cnt_q < lim);

  // Head of the chain feeds the scan unit
  assign head_id = cell_id[0];
  assign head_v  = cell_v[0];

  // Pop/push decisions for the rotation
  assign pop    = ((state_q == ST_SCAN) || (state_q == ST_PURGE)) && (k_q != tot_q);
  assign match  = (state_q == ST_SCAN) && !found_q && (head_id == cand_q);
  assign drop   = pop && (match ||
                  ((state_q == ST_PURGE) && (k_q[IDX_W-1:0] == best_q)));
  assign cnt_m1 = cnt_q - CNT_W'(1);

  // New count for the voted id, saturating
  assign new_v = !found_q ? VOTE_ONE :
                 (hit_votes_q == VOTE_MAX) ? VOTE_MAX : hit_votes_q + VOTE_ONE;

  // Push word goes back in at the tail, or the voted id is appended
  assign load_any = (pop && !drop) || (state_q == ST_APPEND);
  assign tail     = (state_q == ST_APPEND) ? cnt_q[IDX_W-1:0] : cnt_m1[IDX_W-1:0];
  assign push_id  = (state_q == ST_APPEND) ? cand_q : head_id;
  assign push_v   = (state_q == ST_APPEND) ? new_v : head_v;

  // Frame cells
  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    if (i == FRAMES - 1) begin : g_last
      assign nb_id[i] = cell_id[i];
      assign nb_v[i]  = cell_v[i];
    end else begin : g_mid
      assign nb_id[i] = cell_id[i+1];
      assign nb_v[i]  = cell_v[i+1];
    end
    assign cell_ctrl[i].shift = pop;
    assign cell_ctrl[i].load  = load_any && (tail == IDX_W'(i));

    lvfr_cell #(
      .ID_BITS(ID_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl[i]),
      .nb_id_i     (nb_id[i]),
      .nb_votes_i  (nb_v[i]),
      .push_id_i   (push_id),
      .push_votes_i(push_v),
      .id_o        (cell_id[i]),
      .votes_o     (cell_v[i])
    );
  end

  // Sequencer and scan unit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      tot_q       <= '0;
      k_q         <= '0;
      found_q     <= 1'b0;
      have_best_q <= 1'b0;
      evict_q     <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q     <= ST_SCAN;
            tot_q       <= cnt_q;
            k_q         <= '0;
            found_q     <= 1'b0;
            have_best_q <= 1'b0;
            evict_q     <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (!pop) begin
            if (found_q || room) begin
              state_q <= ST_APPEND;
            end else begin
              state_q <= ST_PURGE;
              tot_q   <= cnt_q;
              k_q     <= '0;
            end
          end else begin
            k_q <= k_q + CNT_W'(1);
            if (match) begin
              found_q <= 1'b1;
              cnt_q   <= cnt_m1;
            end else if (!have_best_q || (head_v < best_v_q)) begin
              have_best_q <= 1'b1;
            end
          end
        end
        ST_PURGE: begin
          if (!pop) begin
            state_q <= ST_APPEND;
          end else begin
            k_q <= k_q + CNT_W'(1);
            if (drop) begin
              evict_q <= 1'b1;
              cnt_q   <= cnt_m1;
            end
          end
        end
        ST_APPEND: begin
          cnt_q   <= cnt_q + CNT_W'(1);
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Scan payload: candidate, hit count, least-voted frame, victim id
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && in_valid_i) begin
      cand_q <= candidate_id_i;
      gone_q <= '0;
    end
    if (match && pop) begin
      hit_votes_q <= head_v;
    end
    if ((state_q == ST_SCAN) && pop && !match && (!have_best_q || (head_v < best_v_q))) begin
      best_q   <= k_q[IDX_W-1:0];
      best_v_q <= head_v;
    end
    if ((state_q == ST_PURGE) && drop) begin
      gone_q <= head_id;
    end
  end

  // Output register
  assign out_load = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      was_held_q   <= found_q;
      evict_out_q  <= evict_q;
      evicted_id_q <= gone_q;
      total_q      <= new_v;
      used_q       <= cnt_q;
    end
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign was_held_o    = was_held_q;
  assign evict_valid_o = evict_out_q;
  assign evicted_id_o  = evicted_id_q;
  assign vote_total_o  = total_q;
  assign frames_used_o = used_q;

  // Configuration port
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fiu_q <= FIU_RESET;
    end else if (cfg_wr && (paddr[2] == REG_FRAMES_IN_USE)) begin
      fiu_q <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_FRAMES_IN_USE) ? {{(32-CFG_W){1'b0}}, fiu_q} : '0;

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(FRAMES))
    else $error("occupancy beyond frame count");

  a_evict_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && evict_valid_o) |-> (!was_held_o && (vote_total_o == VOTE_ONE)))
    else $error("eviction on a held id or with a non-fresh count");

  a_used_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frames_used_o != '0))
    else $error("result reports no occupied frame");

  a_evict_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_PURGE) && !pop) |-> (evict_q && (cnt_q == cnt_m1 + CNT_W'(1))))
    else $error("purge pass ended without removing a frame");

endmodule
